>>> src/mhcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor homing package
// Widths, phase codes, register indexes and the saturation helper shared by
// the homing and command select block.
// ----------------------------------------------------------------------------
package mhcs_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int TICK_WIDTH  = 16;

    localparam int GAIN_WIDTH  = 16;
    localparam int SPEED_WIDTH = 31;
    localparam int DIR_WIDTH   = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam int MUL_W   = (VALUE_WIDTH > SPEED_WIDTH) ? VALUE_WIDTH : SPEED_WIDTH;
    localparam int WIDE_W  = MUL_W + 10;
    localparam int CNT_W   = (TICK_WIDTH > GAIN_WIDTH) ? TICK_WIDTH : GAIN_WIDTH;
    localparam int VEL_W   = VALUE_WIDTH + 11;
    localparam int REF_W   = SPEED_WIDTH + GAIN_WIDTH;
    localparam int STALL_W = (VEL_W > REF_W) ? VEL_W : REF_W;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [GAIN_WIDTH-1:0]  gain_t;
    typedef logic [TICK_WIDTH-1:0]  tick_t;
    typedef logic [WIDE_W-1:0]      wide_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SEEK  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_READY = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_GAIN = 3'd0,
        REG_DAMPING_GAIN  = 3'd1,
        REG_GEAR_RATIO    = 3'd2,
        REG_SEEK_SPEED    = 3'd3,
        REG_STALL_TICKS   = 3'd4,
        REG_TIMEOUT_TICKS = 3'd5,
        REG_CALI_DIR      = 3'd6
    } cfg_index_t;

    localparam gain_t GEAR_RESET = GAIN_WIDTH'(256);

    typedef struct packed {
        logic   kind;
        value_t feedback_position;
        value_t feedback_velocity;
        value_t goal_position;
        value_t goal_velocity;
        value_t goal_torque;
        logic   position_given;
        logic   velocity_given;
        logic   torque_given;
    } item_t;

    // Clamps a wide signed value to the signed range of a command value.
    function automatic value_t sat_value(input wide_t x);
        logic [WIDE_W-VALUE_WIDTH:0] top;
        value_t                      res;
        top = x[WIDE_W-1:VALUE_WIDTH-1];
        if ((&top) || !(|top))
        begin
            res = x[VALUE_WIDTH-1:0];
        end
        else if (x[WIDE_W-1])
        begin
            res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic wide_t widen(input value_t v);
        return {{(WIDE_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
    endfunction

    function automatic tick_t inc_sat(input tick_t c);
        return (&c) ? c : c + tick_t'(1);
    endfunction

endpackage

>>> src/motor_homing_and_command_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor homing and command select
// Seeks a hard stop by stall detection or waits out a calibration delay, then
// selects motor commands from goal requests.
// ----------------------------------------------------------------------------
// An item is registered on acceptance; its result enters the command state
// when it advances, which a stalled output holds back. Throughput: one item
// per cycle unless the output stalls; the gear multiplier and the stall
// compare sit in the single stage between the input register and the command
// state. Reset: all commands, counters and the zero offset clear, the gear
// ratio returns to 1.0 and calibration restarts on the first update tick.
module motor_homing_and_command_select (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [mhcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mhcs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [mhcs_pkg::VALUE_WIDTH-1:0]  feedback_position,
    input  logic [mhcs_pkg::VALUE_WIDTH-1:0]  feedback_velocity,
    input  logic [mhcs_pkg::VALUE_WIDTH-1:0]  goal_position,
    input  logic [mhcs_pkg::VALUE_WIDTH-1:0]  goal_velocity,
    input  logic [mhcs_pkg::VALUE_WIDTH-1:0]  goal_torque,
    input  logic                              position_given,
    input  logic                              velocity_given,
    input  logic                              torque_given,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mhcs_pkg::GAIN_WIDTH-1:0]   cmd_kp,
    output logic [mhcs_pkg::GAIN_WIDTH-1:0]   cmd_kd,
    output logic [mhcs_pkg::VALUE_WIDTH-1:0]  cmd_q,
    output logic [mhcs_pkg::VALUE_WIDTH-1:0]  cmd_dq,
    output logic [mhcs_pkg::VALUE_WIDTH-1:0]  cmd_tau,
    output logic                              ready_res,
    output logic                              zero_found
);
    import mhcs_pkg::*;

    gain_t                  position_gain_reg;
    gain_t                  damping_gain_reg;
    gain_t                  gear_ratio_reg;
    logic [SPEED_WIDTH-1:0] seek_speed_reg;
    gain_t                  stall_ticks_reg;
    gain_t                  timeout_ticks_reg;
    logic [DIR_WIDTH-1:0]   cali_dir_reg;

    logic   in_valid_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    logic   advance;

    phase_t phase_reg,    phase_next;
    tick_t  elapsed_reg,  elapsed_next;
    tick_t  still_reg,    still_next;
    value_t zero_reg,     zero_next;
    logic   found_reg,    found_next;
    gain_t  kp_reg,       kp_next;
    gain_t  kd_reg,       kd_next;
    value_t q_reg,        q_next;
    value_t dq_reg,       dq_next;
    value_t tau_reg,      tau_next;

    value_t                 goal_sel;
    logic [MUL_W-1:0]       mul_mag;
    logic                   mul_neg;
    logic [MUL_W+15:0]      mul_prod;
    logic [MUL_W+7:0]       mul_shift;
    wide_t                  mul_wide;
    value_t                 scaled;
    value_t                 vel_mag;
    logic [STALL_W-1:0]     vel_term;
    logic [STALL_W-1:0]     ref_term;
    logic                   moving;
    logic                   dir_zero;
    phase_t                 phase_v;
    tick_t                  still_inc;
    tick_t                  elapsed_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;

    assign cmd_kp     = kp_reg;
    assign cmd_kd     = kd_reg;
    assign cmd_q      = q_reg;
    assign cmd_dq     = dq_reg;
    assign cmd_tau    = tau_reg;
    assign ready_res  = (phase_reg == PH_READY);
    assign zero_found = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_gain_reg <= '0;
            damping_gain_reg  <= '0;
            gear_ratio_reg    <= GEAR_RESET;
            seek_speed_reg    <= '0;
            stall_ticks_reg   <= '0;
            timeout_ticks_reg <= '0;
            cali_dir_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POSITION_GAIN: position_gain_reg <= cfg_data[GAIN_WIDTH-1:0];
                REG_DAMPING_GAIN:  damping_gain_reg  <= cfg_data[GAIN_WIDTH-1:0];
                REG_GEAR_RATIO:    gear_ratio_reg    <= cfg_data[GAIN_WIDTH-1:0];
                REG_SEEK_SPEED:    seek_speed_reg    <= cfg_data[SPEED_WIDTH-1:0];
                REG_STALL_TICKS:   stall_ticks_reg   <= cfg_data[GAIN_WIDTH-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[GAIN_WIDTH-1:0];
                REG_CALI_DIR:      cali_dir_reg      <= cfg_data[DIR_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind              <= kind;
            item_reg.feedback_position <= feedback_position;
            item_reg.feedback_velocity <= feedback_velocity;
            item_reg.goal_position     <= goal_position;
            item_reg.goal_velocity     <= goal_velocity;
            item_reg.goal_torque       <= goal_torque;
            item_reg.position_given    <= position_given;
            item_reg.velocity_given    <= velocity_given;
            item_reg.torque_given      <= torque_given;
        end
    end

    // One gear multiplier serves the seek speed on ticks and the chosen goal.
    always_comb
    begin
        dir_zero = (cali_dir_reg == '0);
        goal_sel = item_reg.velocity_given ? item_reg.goal_velocity : item_reg.goal_position;
        if (!item_reg.kind)
        begin
            mul_mag = dir_zero ? '0 : MUL_W'(seek_speed_reg);
            mul_neg = cali_dir_reg[DIR_WIDTH-1];
        end
        else
        begin
            mul_neg = goal_sel[VALUE_WIDTH-1];
            mul_mag = MUL_W'(mul_neg ? value_t'(-goal_sel) : goal_sel);
        end
        mul_prod  = mul_mag * (MUL_W+16)'(gear_ratio_reg);
        mul_shift = mul_prod[MUL_W+15:8];
        mul_wide  = mul_neg ? wide_t'(-{2'b00, mul_shift}) : {2'b00, mul_shift};
        scaled    = sat_value(mul_wide);

        vel_mag = item_reg.feedback_velocity[VALUE_WIDTH-1]
                ? value_t'(-item_reg.feedback_velocity) : item_reg.feedback_velocity;
        vel_term = (STALL_W'(vel_mag) << 10) + (STALL_W'(vel_mag) << 8);
        ref_term = STALL_W'(seek_speed_reg) * STALL_W'(gear_ratio_reg);
        moving   = (vel_term > ref_term);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        still_next   = still_reg;
        zero_next    = zero_reg;
        found_next   = found_reg;
        kp_next      = kp_reg;
        kd_next      = kd_reg;
        q_next       = q_reg;
        dq_next      = dq_reg;
        tau_next     = tau_reg;
        phase_v      = phase_reg;
        still_inc    = moving ? '0 : inc_sat(still_reg);
        elapsed_inc  = inc_sat(elapsed_reg);

        if (advance && !item_reg.kind)
        begin
            if (phase_v == PH_START)
            begin
                phase_v = dir_zero ? PH_WAIT : PH_SEEK;
            end
            if (phase_v == PH_SEEK)
            begin
                if (CNT_W'(elapsed_reg) >= CNT_W'(timeout_ticks_reg))
                begin
                    zero_next = '0;
                    kp_next   = '0;
                    kd_next   = damping_gain_reg;
                    q_next    = '0;
                    dq_next   = '0;
                    tau_next  = '0;
                    phase_v   = PH_WAIT;
                end
                else
                begin
                    kd_next    = damping_gain_reg;
                    dq_next    = scaled;
                    still_next = still_inc;
                    if (CNT_W'(still_inc) > CNT_W'(stall_ticks_reg))
                    begin
                        zero_next  = item_reg.feedback_position;
                        found_next = 1'b1;
                        kp_next    = position_gain_reg;
                        kd_next    = '0;
                        q_next     = item_reg.feedback_position;
                        dq_next    = '0;
                        tau_next   = '0;
                        phase_v    = PH_WAIT;
                    end
                end
            end
            elapsed_next = elapsed_inc;
            if (phase_v == PH_WAIT && CNT_W'(elapsed_inc) >= CNT_W'(timeout_ticks_reg))
            begin
                phase_v = PH_READY;
            end
            phase_next = phase_v;
        end
        else if (advance && phase_reg == PH_READY)
        begin
            if (item_reg.velocity_given)
            begin
                kd_next  = damping_gain_reg;
                kp_next  = '0;
                q_next   = '0;
                dq_next  = scaled;
                tau_next = '0;
            end
            else if (item_reg.position_given)
            begin
                kd_next  = '0;
                kp_next  = position_gain_reg;
                q_next   = sat_value(widen(scaled) + widen(zero_reg));
                dq_next  = '0;
                tau_next = '0;
            end
            else if (item_reg.torque_given)
            begin
                kd_next  = '0;
                kp_next  = '0;
                q_next   = '0;
                dq_next  = '0;
                tau_next = item_reg.goal_torque;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            elapsed_reg <= '0;
            still_reg   <= '0;
            zero_reg    <= '0;
            found_reg   <= 1'b0;
            kp_reg      <= '0;
            kd_reg      <= '0;
            q_reg       <= '0;
            dq_reg      <= '0;
            tau_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            still_reg   <= still_next;
            zero_reg    <= zero_next;
            found_reg   <= found_next;
            kp_reg      <= kp_next;
            kd_reg      <= kd_next;
            q_reg       <= q_next;
            dq_reg      <= dq_next;
            tau_reg     <= tau_next;
        end
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor homing and command select testbench
// Drives update ticks and goal requests through the valid/ready input channel
// while an in-house predictor of the homing sequence and the goal selection
// works out each command item. The calibration part covers the seek, the
// stall counter, live direction changes and the early goals, and is followed
// by random phases under several gain and gear settings. Both channels idle
// at random, but for one phase in which neither idles.
// ----------------------------------------------------------------------------
module tb;
    import mhcs_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     PHASE_ITEMS  = 150;
    localparam longint VAL_MAX      = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint VAL_MIN      = -VAL_MAX - 1;
    localparam value_t TOP_VALUE    = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t BOTTOM_VALUE = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        gain_t  kp;
        gain_t  kd;
        value_t q;
        value_t dq;
        value_t tau;
        logic   rdy;
        logic   zf;
    } cmd_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    item_t                 cur_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    gain_t                 cmd_kp;
    gain_t                 cmd_kd;
    value_t                cmd_q;
    value_t                cmd_dq;
    value_t                cmd_tau;
    logic                  ready_res;
    logic                  zero_found;

    item_t pending_items[$];
    cmd_t  cmd_due[$];
    cmd_t  want_cmd;
    logic  in_fire = 1'b0;
    int    src_idle = 14;
    int    sink_idle = 14;
    int    errors = 0;
    int    cycle_count = 0;

    // Predictor state, mirroring the block after reset.
    phase_t          ph = PH_START;
    tick_t           elapsed_cnt = '0;
    tick_t           still_cnt = '0;
    longint          zero_ofs = 0;
    logic            found = 1'b0;
    gain_t           hold_kp = '0;
    gain_t           hold_kd = '0;
    longint          hold_q = 0;
    longint          hold_dq = 0;
    longint          hold_tau = 0;
    gain_t           cfg_kp = '0;
    gain_t           cfg_kd = '0;
    longint unsigned cfg_gear = 256;
    longint unsigned cfg_speed = 0;
    tick_t           cfg_stall = '0;
    tick_t           cfg_timeout = '0;
    logic [1:0]      cfg_dir = '0;

    motor_homing_and_command_select dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (cur_item.kind),
        .feedback_position (cur_item.feedback_position),
        .feedback_velocity (cur_item.feedback_velocity),
        .goal_position     (cur_item.goal_position),
        .goal_velocity     (cur_item.goal_velocity),
        .goal_torque       (cur_item.goal_torque),
        .position_given    (cur_item.position_given),
        .velocity_given    (cur_item.velocity_given),
        .torque_given      (cur_item.torque_given),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .cmd_kp            (cmd_kp),
        .cmd_kd            (cmd_kd),
        .cmd_q             (cmd_q),
        .cmd_dq            (cmd_dq),
        .cmd_tau           (cmd_tau),
        .ready_res         (ready_res),
        .zero_found        (zero_found)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_value(input longint x);
        if (x > VAL_MAX)
        begin
            return VAL_MAX;
        end
        if (x < VAL_MIN)
        begin
            return VAL_MIN;
        end
        return x;
    endfunction

    // Output side value times the gear ratio in Q8.8, truncated toward zero.
    function automatic longint gear_scale(input longint v);
        longint unsigned mag;
        longint unsigned p;
        mag = (v < 0) ? -v : v;
        p = (mag * cfg_gear) >> 8;
        return clamp_value((v < 0) ? -longint'(p) : longint'(p));
    endfunction

    function automatic cmd_t homing_step(input item_t it);
        longint          fpos;
        longint          fvel;
        longint          spd;
        longint unsigned fmag;
        int              d;
        cmd_t            r;
        fpos = $signed(it.feedback_position);
        fvel = $signed(it.feedback_velocity);
        d = $signed(cfg_dir);
        if (!it.kind)
        begin
            if (ph == PH_START)
            begin
                ph = (d == 0) ? PH_WAIT : PH_SEEK;
            end
            if (ph == PH_SEEK)
            begin
                if (elapsed_cnt >= cfg_timeout)
                begin
                    zero_ofs = 0;
                    hold_kp = '0;
                    hold_kd = cfg_kd;
                    hold_q = 0;
                    hold_dq = 0;
                    hold_tau = 0;
                    ph = PH_WAIT;
                end
                else
                begin
                    spd = (d < 0) ? -longint'(cfg_speed) : ((d == 0) ? 0 : longint'(cfg_speed));
                    hold_kd = cfg_kd;
                    hold_dq = gear_scale(spd);
                    fmag = (fvel < 0) ? -fvel : fvel;
                    if (fmag * 1280 > cfg_speed * cfg_gear)
                    begin
                        still_cnt = '0;
                    end
                    else if (still_cnt != '1)
                    begin
                        still_cnt = still_cnt + 1'b1;
                    end
                    if (still_cnt > cfg_stall)
                    begin
                        zero_ofs = fpos;
                        found = 1'b1;
                        hold_kp = cfg_kp;
                        hold_kd = '0;
                        hold_q = clamp_value(zero_ofs);
                        hold_dq = 0;
                        hold_tau = 0;
                        ph = PH_WAIT;
                    end
                end
            end
            if (elapsed_cnt != '1)
            begin
                elapsed_cnt = elapsed_cnt + 1'b1;
            end
            if (ph == PH_WAIT && elapsed_cnt >= cfg_timeout)
            begin
                ph = PH_READY;
            end
        end
        else if (ph == PH_READY)
        begin
            if (it.velocity_given)
            begin
                hold_kd = cfg_kd;
                hold_kp = '0;
                hold_q = 0;
                hold_dq = gear_scale($signed(it.goal_velocity));
                hold_tau = 0;
            end
            else if (it.position_given)
            begin
                hold_kd = '0;
                hold_kp = cfg_kp;
                hold_q = clamp_value(gear_scale($signed(it.goal_position)) + zero_ofs);
                hold_dq = 0;
                hold_tau = 0;
            end
            else if (it.torque_given)
            begin
                hold_kd = '0;
                hold_kp = '0;
                hold_q = 0;
                hold_dq = 0;
                hold_tau = $signed(it.goal_torque);
            end
        end
        r.kp = hold_kp;
        r.kd = hold_kd;
        r.q = hold_q[VALUE_WIDTH-1:0];
        r.dq = hold_dq[VALUE_WIDTH-1:0];
        r.tau = hold_tau[VALUE_WIDTH-1:0];
        r.rdy = (ph == PH_READY);
        r.zf = found;
        return r;
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 7))
            0: return TOP_VALUE;
            1: return BOTTOM_VALUE;
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic longint unsigned pick16();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Velocities either side of the stall threshold for a seek speed of 1.0
    // and a gear ratio of 1.0.
    function automatic value_t still_vel();
        value_t v;
        v = ($urandom_range(0, 3) == 0) ? 13107 : $urandom_range(0, 13107);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic value_t moving_vel();
        value_t v;
        if ($urandom_range(0, 3) == 0)
        begin
            return BOTTOM_VALUE;
        end
        v = ($urandom_range(0, 3) == 0) ? 13108 : $urandom_range(13108, 32'h7FFFFFFF);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic item_t mk_tick(input value_t pos, input value_t vel);
        item_t it;
        it.kind = 1'b0;
        it.feedback_position = pos;
        it.feedback_velocity = vel;
        it.goal_position = $urandom;
        it.goal_velocity = $urandom;
        it.goal_torque = $urandom;
        it.position_given = $urandom_range(0, 1);
        it.velocity_given = $urandom_range(0, 1);
        it.torque_given = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic item_t mk_goal(input logic vg, input logic pg, input logic tg,
                                      input value_t gp, input value_t gv, input value_t gt);
        item_t it;
        it.kind = 1'b1;
        it.feedback_position = $urandom;
        it.feedback_velocity = $urandom;
        it.goal_position = gp;
        it.goal_velocity = gv;
        it.goal_torque = gt;
        it.position_given = pg;
        it.velocity_given = vg;
        it.torque_given = tg;
        return it;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input longint unsigned val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_POSITION_GAIN: cfg_kp = val[GAIN_WIDTH-1:0];
            REG_DAMPING_GAIN:  cfg_kd = val[GAIN_WIDTH-1:0];
            REG_GEAR_RATIO:    cfg_gear = val[GAIN_WIDTH-1:0];
            REG_SEEK_SPEED:    cfg_speed = val[SPEED_WIDTH-1:0];
            REG_STALL_TICKS:   cfg_stall = val[TICK_WIDTH-1:0];
            REG_TIMEOUT_TICKS: cfg_timeout = val[TICK_WIDTH-1:0];
            REG_CALI_DIR:      cfg_dir = val[DIR_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_all(input longint unsigned kp, input longint unsigned kd,
                           input longint unsigned gear, input longint unsigned speed,
                           input longint unsigned stall, input longint unsigned timeout,
                           input longint unsigned dir);
        write_reg(REG_POSITION_GAIN, kp);
        write_reg(REG_DAMPING_GAIN, kd);
        write_reg(REG_GEAR_RATIO, gear);
        write_reg(REG_SEEK_SPEED, speed);
        write_reg(REG_STALL_TICKS, stall);
        write_reg(REG_TIMEOUT_TICKS, timeout);
        write_reg(REG_CALI_DIR, dir);
    endtask

    // Holds the sender back until every item has been answered.
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || cmd_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle)
            begin
                cur_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            cmd_due.push_back(homing_step(cur_item));
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (cmd_due.size() == 0)
            begin
                $display("%0t: unexpected command item, expected none, actual %h %h %h %h %h",
                         $time, cmd_kp, cmd_kd, cmd_q, cmd_dq, cmd_tau);
                errors++;
            end
            else
            begin
                want_cmd = cmd_due.pop_front();
                check_field("cmd_kp", want_cmd.kp, cmd_kp);
                check_field("cmd_kd", want_cmd.kd, cmd_kd);
                check_field("cmd_q", want_cmd.q, cmd_q);
                check_field("cmd_dq", want_cmd.dq, cmd_dq);
                check_field("cmd_tau", want_cmd.tau, cmd_tau);
                check_field("ready_res", want_cmd.rdy, ready_res);
                check_field("zero_found", want_cmd.zf, zero_found);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int              home_path;
        longint unsigned home_dir;
        longint unsigned gear;
        longint unsigned speed;
        int              roll;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The homing outcome is fixed at the first tick, so each seed picks
        // one of a disabled search, a timed-out seek or a found hard stop.
        home_path = $urandom_range(0, 3);
        home_dir = (home_path == 0) ? 0 : 1;
        set_all($urandom_range(0, 65535), $urandom_range(0, 65535), 256, 65536,
                (home_path == 1) ? 65535 : 4, 12, home_dir);

        pending_items.push_back(mk_goal(1, 1, 1, pick_value(), pick_value(), pick_value()));
        pending_items.push_back(mk_tick(pick_value(), moving_vel()));
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        pending_items.push_back(mk_tick(pick_value(), moving_vel()));
        drain();
        write_reg(REG_CALI_DIR, 3);
        pending_items.push_back(mk_tick(pick_value(), moving_vel()));
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        drain();
        write_reg(REG_CALI_DIR, 2);
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        drain();
        write_reg(REG_CALI_DIR, 0);
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        drain();
        write_reg(REG_CALI_DIR, home_dir);
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        pending_items.push_back(mk_tick(pick_value(), still_vel()));
        pending_items.push_back(mk_goal(0, 1, 0, pick_value(), pick_value(), pick_value()));
        repeat (5)
        begin
            pending_items.push_back(mk_tick(pick_value(), still_vel()));
        end
        pending_items.push_back(mk_goal(1, 1, 1, pick_value(), TOP_VALUE, pick_value()));
        pending_items.push_back(mk_goal(1, 0, 0, pick_value(), BOTTOM_VALUE, pick_value()));
        pending_items.push_back(mk_goal(0, 1, 1, TOP_VALUE, pick_value(), pick_value()));
        pending_items.push_back(mk_goal(0, 1, 0, BOTTOM_VALUE, pick_value(), pick_value()));
        pending_items.push_back(mk_goal(0, 0, 1, pick_value(), pick_value(), TOP_VALUE));
        pending_items.push_back(mk_goal(0, 0, 1, pick_value(), pick_value(), BOTTOM_VALUE));
        pending_items.push_back(mk_goal(0, 0, 0, pick_value(), pick_value(), pick_value()));
        pending_items.push_back(mk_goal(0, 1, 0, '0, pick_value(), pick_value()));
        pending_items.push_back(mk_tick(BOTTOM_VALUE, TOP_VALUE));

        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0: gear = 256;
                1: gear = 0;
                2: gear = 65535;
                3: gear = 1;
                default: gear = $urandom_range(0, 65535);
            endcase
            speed = (p % 3 == 0) ? 32'h7FFFFFFF : ((p % 3 == 1) ? 0 : $urandom_range(0, 32'h7FFFFFFF));
            set_all((p == 1) ? 0 : ((p == 2) ? 65535 : pick16()),
                    (p == 1) ? 65535 : ((p == 2) ? 0 : pick16()),
                    gear, speed, pick16(), pick16(), $urandom_range(0, 3));
            src_idle = (p == 2) ? 0 : 14;
            sink_idle = (p == 2) ? 0 : 14;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                begin
                    pending_items.push_back(mk_tick(pick_value(), pick_value()));
                end
                else
                begin
                    pending_items.push_back(mk_goal($urandom_range(0, 1), $urandom_range(0, 1),
                                                    $urandom_range(0, 1), pick_value(),
                                                    pick_value(), pick_value()));
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
